### sv/vle_pkg.sv
`timescale 1ns / 1ps

package vle_pkg;

    // Key bytes
    localparam logic [7:0] K_ESC   = 8'h1B;
    localparam logic [7:0] K_BS    = 8'h08;
    localparam logic [7:0] K_DEL   = 8'h7F;
    localparam logic [7:0] K_CR    = 8'h0D;
    localparam logic [7:0] K_LF    = 8'h0A;
    localparam logic [7:0] K_LBRK  = 8'h5B;  // '['
    localparam logic [7:0] K_SS3   = 8'h4F;  // 'O'
    localparam logic [7:0] K_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] K_THREE = 8'h33;  // '3'
    localparam logic [7:0] K_RIGHT = 8'h43;  // 'C'
    localparam logic [7:0] K_LEFT  = 8'h44;  // 'D'
    localparam logic [7:0] K_HOME  = 8'h48;  // 'H'
    localparam logic [7:0] K_END   = 8'h46;  // 'F'
    localparam logic [7:0] K_PR_LO = 8'h20;
    localparam logic [7:0] K_PR_HI = 8'h7E;

    // Event codes on the result
    localparam logic [1:0] EV_ABSORB = 2'd0;
    localparam logic [1:0] EV_CHANGE = 2'd1;
    localparam logic [1:0] EV_SUBMIT = 2'd2;
    localparam logic [1:0] EV_CANCEL = 2'd3;

    // Line limit reset value and hard cap
    localparam logic [5:0] LIMIT_RESET = 6'd32;
    localparam int         RESULT_CAP  = 32;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Commands handed from the front to the back
    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_CANCEL = 4'd1,
        OP_INS    = 4'd2,
        OP_BKSP   = 4'd3,
        OP_DEL    = 4'd4,
        OP_LEFT   = 4'd5,
        OP_RIGHT  = 4'd6,
        OP_HOME   = 4'd7,
        OP_END    = 4'd8,
        OP_SUBMIT = 4'd9
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    // Escape parser phase
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_ESC  = 5'b00010,
        PH_CSI  = 5'b00100,
        PH_SS3  = 5'b01000,
        PH_CSI3 = 5'b10000
    } t_phase;

    // Back-end sequencer
    typedef enum logic [2:0] {
        BS_IDLE  = 3'b001,
        BS_SHIFT = 3'b010,
        BS_EMIT  = 3'b100
    } t_bstate;

endpackage

### sv/vle_front.sv
`timescale 1ns / 1ps

module vle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_func,
    input  logic [7:0]    i_key_code,
    output vle_pkg::t_cmd o_cmd
);
    import vle_pkg::*;

    t_phase r_phase, n_phase;
    t_cmd   cmd;

    // Map a CSI/SS3 final byte to a cursor move
    function automatic t_op move_op(input logic [7:0] ch);
        t_op op;
        case (ch)
            K_RIGHT: op = OP_RIGHT;
            K_LEFT:  op = OP_LEFT;
            K_HOME:  op = OP_HOME;
            K_END:   op = OP_END;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    // Classify the item and advance the escape parser
    always_comb begin
        n_phase = r_phase;
        cmd.op  = OP_NOP;
        cmd.ch  = i_key_code;
        if (i_func) begin
            if (r_phase == PH_ESC) begin
                cmd.op  = OP_CANCEL;
                n_phase = PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_ESC: begin
                    if (i_key_code == K_LBRK) begin
                        n_phase = PH_CSI;
                    end else if (i_key_code == K_SS3) begin
                        n_phase = PH_SS3;
                    end else begin
                        cmd.op  = OP_CANCEL;
                        n_phase = PH_IDLE;
                    end
                end
                PH_CSI: begin
                    if (i_key_code == K_THREE) begin
                        n_phase = PH_CSI3;
                    end else begin
                        cmd.op  = move_op(i_key_code);
                        n_phase = PH_IDLE;
                    end
                end
                PH_SS3: begin
                    cmd.op  = move_op(i_key_code);
                    n_phase = PH_IDLE;
                end
                PH_CSI3: begin
                    if (i_key_code == K_TILDE) begin
                        cmd.op = OP_DEL;
                    end
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_key_code == K_CR || i_key_code == K_LF) begin
                        cmd.op = OP_SUBMIT;
                    end else if (i_key_code == K_ESC) begin
                        n_phase = PH_ESC;
                    end else if (i_key_code == K_BS || i_key_code == K_DEL) begin
                        cmd.op = OP_BKSP;
                    end else if (i_key_code inside {[K_PR_LO:K_PR_HI]}) begin
                        cmd.op = OP_INS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_push) begin
            r_phase <= n_phase;
        end
    end

    assign o_cmd = cmd;

endmodule

### sv/vle_cmd_fifo.sv
`timescale 1ns / 1ps

module vle_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vle_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output vle_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import vle_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_q[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/vle_back.sv
`timescale 1ns / 1ps

module vle_back #(
    parameter int LINE_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [5:0]    i_cfg_wdata,
    input  vle_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    output logic [1:0]    o_event_res,
    output logic [7:0]    o_char_out,
    output logic          o_char_valid,
    output logic [5:0]    o_cursor_pos,
    output logic [5:0]    o_line_length,
    output logic          o_last
);
    import vle_pkg::*;

    localparam int         IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [5:0] CAP   = 6'((LINE_DEPTH < RESULT_CAP) ? LINE_DEPTH : RESULT_CAP);

    // Line memory
    logic [7:0] r_mem [LINE_DEPTH];
    logic [7:0] r_rd_data;
    logic       mem_we;
    logic [5:0] mem_wa, mem_ra;
    logic [7:0] mem_wd;

    // Editor state
    t_bstate    r_state, n_state;
    logic [5:0] r_limit;
    logic [5:0] r_cursor, n_cursor;
    logic [5:0] r_length, n_length;
    logic [5:0] r_ptr, n_ptr;
    logic [5:0] r_cnt, n_cnt;
    logic [5:0] r_wa, n_wa;
    logic       r_pend, n_pend;
    t_op        r_op, n_op;
    logic [7:0] r_ch, n_ch;

    // Result register
    logic       r_ov, n_ov;
    logic [1:0] r_ev, n_ev;
    logic [7:0] r_co, n_co;
    logic       r_cv, n_cv;
    logic [5:0] r_cur, n_cur;
    logic [5:0] r_len, n_len;
    logic       r_last, n_last;

    logic [5:0] eff_lim;

    assign eff_lim = (r_limit > CAP) ? CAP : r_limit;
    assign o_pop   = (r_state == BS_IDLE) && !i_empty;

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_length = r_length;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_wa     = r_wa;
        n_pend   = 1'b0;
        n_op     = r_op;
        n_ch     = r_ch;
        mem_we   = 1'b0;
        mem_wa   = r_wa;
        mem_wd   = r_rd_data;
        mem_ra   = r_ptr;
        n_ov     = 1'b0;
        n_ev     = EV_ABSORB;
        n_co     = 8'd0;
        n_cv     = 1'b0;
        n_cur    = r_cursor;
        n_len    = r_length;
        n_last   = 1'b1;

        case (r_state)
            // Take one command; simple ones finish here
            BS_IDLE: begin
                if (!i_empty) begin
                    n_op = i_cmd.op;
                    n_ch = i_cmd.ch;
                    n_ov = 1'b1;
                    case (i_cmd.op)
                        OP_CANCEL: begin
                            n_ev     = EV_CANCEL;
                            n_cursor = 6'd0;
                            n_length = 6'd0;
                        end
                        OP_RIGHT: begin
                            if (r_cursor < r_length) begin
                                n_cursor = r_cursor + 6'd1;
                                n_ev     = EV_CHANGE;
                            end
                        end
                        OP_LEFT: begin
                            if (r_cursor != 6'd0) begin
                                n_cursor = r_cursor - 6'd1;
                                n_ev     = EV_CHANGE;
                            end
                        end
                        OP_HOME: begin
                            n_cursor = 6'd0;
                            if (r_cursor != 6'd0) begin
                                n_ev = EV_CHANGE;
                            end
                        end
                        OP_END: begin
                            n_cursor = r_length;
                            if (r_cursor != r_length) begin
                                n_ev = EV_CHANGE;
                            end
                        end
                        OP_INS: begin
                            if (r_length < eff_lim) begin
                                n_ov    = 1'b0;
                                n_state = BS_SHIFT;
                                n_ptr   = r_length - 6'd1;
                                n_cnt   = r_length - r_cursor;
                            end
                        end
                        OP_BKSP: begin
                            if (r_cursor != 6'd0) begin
                                n_ov    = 1'b0;
                                n_state = BS_SHIFT;
                                n_ptr   = r_cursor;
                                n_cnt   = r_length - r_cursor;
                            end
                        end
                        OP_DEL: begin
                            if (r_cursor < r_length) begin
                                n_ov    = 1'b0;
                                n_state = BS_SHIFT;
                                n_ptr   = r_cursor + 6'd1;
                                n_cnt   = r_length - r_cursor - 6'd1;
                            end
                        end
                        OP_SUBMIT: begin
                            n_ev = EV_SUBMIT;
                            if (r_length != 6'd0) begin
                                n_ov    = 1'b0;
                                n_state = BS_EMIT;
                                n_ptr   = 6'd0;
                                n_cnt   = r_length;
                            end
                        end
                        default: begin
                            n_ev = EV_ABSORB;
                        end
                    endcase
                    // Moves report the new cursor; a cancel reports the line before clearing
                    if (i_cmd.op != OP_CANCEL) begin
                        n_cur = n_cursor;
                        n_len = n_length;
                    end
                end
            end

            // Move one character per cycle: read ahead, write the word read last cycle
            BS_SHIFT: begin
                if (r_cnt != 6'd0) begin
                    mem_ra = r_ptr;
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - 6'd1;
                    if (r_op == OP_INS) begin
                        n_wa  = r_ptr + 6'd1;
                        n_ptr = r_ptr - 6'd1;
                    end else begin
                        n_wa  = r_ptr - 6'd1;
                        n_ptr = r_ptr + 6'd1;
                    end
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                end else if (r_cnt == 6'd0) begin
                    n_state = BS_IDLE;
                    n_ov    = 1'b1;
                    n_ev    = EV_CHANGE;
                    case (r_op)
                        OP_INS: begin
                            mem_we   = 1'b1;
                            mem_wa   = r_cursor;
                            mem_wd   = r_ch;
                            n_cursor = r_cursor + 6'd1;
                            n_length = r_length + 6'd1;
                        end
                        OP_BKSP: begin
                            n_cursor = r_cursor - 6'd1;
                            n_length = r_length - 6'd1;
                        end
                        default: begin
                            n_length = r_length - 6'd1;
                        end
                    endcase
                    n_cur = n_cursor;
                    n_len = n_length;
                end
            end

            // Stream the line out, one character per cycle
            BS_EMIT: begin
                if (r_cnt != 6'd0) begin
                    mem_ra = r_ptr;
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - 6'd1;
                    n_ptr  = r_ptr + 6'd1;
                end
                if (r_pend) begin
                    n_ov   = 1'b1;
                    n_ev   = EV_SUBMIT;
                    n_co   = r_rd_data;
                    n_cv   = 1'b1;
                    n_last = (r_cnt == 6'd0);
                    if (r_cnt == 6'd0) begin
                        n_state  = BS_IDLE;
                        n_cursor = 6'd0;
                        n_length = 6'd0;
                    end
                end
            end

            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Line memory ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa[IDX_W-1:0]] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra[IDX_W-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_limit  <= LIMIT_RESET;
            r_cursor <= 6'd0;
            r_length <= 6'd0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_cursor <= n_cursor;
            r_length <= n_length;
            r_pend   <= n_pend;
            r_ov     <= n_ov;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_wa   <= n_wa;
        r_op   <= n_op;
        r_ch   <= n_ch;
        r_ev   <= n_ev;
        r_co   <= n_co;
        r_cv   <= n_cv;
        r_cur  <= n_cur;
        r_len  <= n_len;
        r_last <= n_last;
    end

    assign o_valid       = r_ov;
    assign o_event_res   = r_ev;
    assign o_char_out    = r_co;
    assign o_char_valid  = r_cv;
    assign o_cursor_pos  = r_cur;
    assign o_line_length = r_len;
    assign o_last        = r_last;

endmodule

### sv/vt100_line_editor.sv
`timescale 1ns / 1ps
// Simple keys give their result through the command queue and the back-end result register;
// an insert or delete first moves the characters behind the cursor in the line memory, and
// a submit streams the line one character per cycle. The receiver cannot stall.
// Throughput: one simple key per cycle while busy is low; an edit or submit holds the back
// end while a 2-entry command queue takes further keys. Synchronous active-low reset
// clears cursor, length, parser phase and queue, and sets the line limit to 32.
module vt100_line_editor #(
    parameter int LINE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_func,
    input  logic [7:0] i_key_code,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [1:0] o_event_res,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic [5:0] o_cursor_pos,
    output logic [5:0] o_line_length,
    output logic       o_last
);
    import vle_pkg::*;

    logic push, pop, q_empty, q_full;
    t_cmd f_cmd, q_cmd;

    assign busy = q_full;
    assign push = start && !q_full;

    // Front: escape parse and key classification
    vle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_func     (i_func),
        .i_key_code (i_key_code),
        .o_cmd      (f_cmd)
    );

    // Command queue
    vle_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: line memory and edit sequencer
    vle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (q_cmd),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_event_res   (o_event_res),
        .o_char_out    (o_char_out),
        .o_char_valid  (o_char_valid),
        .o_cursor_pos  (o_cursor_pos),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

endmodule

### sv/vle_checker.sv
`timescale 1ns / 1ps

module vle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_event_res,
    input logic       o_char_valid,
    input logic [5:0] o_cursor_pos,
    input logic [5:0] o_line_length,
    input logic       o_last
);
    import vle_pkg::*;

    // Cursor never passes the end of the line
    a_cur_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_pos <= o_line_length))
        else $error("cursor beyond line length");

    // Only submitted lines carry characters
    a_char_submit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_valid) |-> (o_event_res == EV_SUBMIT))
        else $error("character outside a submit");

    // A submitted line streams without gaps until its last character
    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && o_event_res == EV_SUBMIT))
        else $error("gap in submitted line");

    // Everything but a submit is a single result
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res != EV_SUBMIT) |-> o_last)
        else $error("multi-result non-submit");

    // Busy only rises right after an accepted item
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy without an accepted item");

endmodule

bind vt100_line_editor vle_checker u_vle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_event_res   (o_event_res),
    .o_char_valid  (o_char_valid),
    .o_cursor_pos  (o_cursor_pos),
    .o_line_length (o_line_length),
    .o_last        (o_last)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import vle_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 28;
    localparam int N_PHASES    = 5;

    // One result of the editor, field by field
    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] ch;
        logic       cv;
        logic [5:0] cur;
        logic [5:0] len;
        logic       last;
    } t_line_result;

    // Directed row: key item plus an optional hand-written result
    typedef struct packed {
        logic       func;
        logic [7:0] key;
        logic       typed;
        logic [1:0] ev;
        logic [5:0] cur;
        logic [5:0] len;
    } t_key_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       i_func      = 1'b0;
    logic [7:0] i_key_code  = 8'h00;
    logic       i_cfg_we    = 1'b0;
    logic [5:0] i_cfg_wdata = 6'd0;
    logic       busy;
    logic       o_valid;
    logic [1:0] o_event_res;
    logic [7:0] o_char_out;
    logic       o_char_valid;
    logic [5:0] o_cursor_pos;
    logic [5:0] o_line_length;
    logic       o_last;

    // Editor state as predicted
    logic [7:0] ed_line [DEPTH];
    int         ed_cursor;
    int         ed_length;
    t_phase     ed_phase;
    logic [5:0] ed_limit;

    t_line_result pending_results [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    t_key_row directed_rows [N_DIRECTED] = '{
        '{1'b1, 8'hFF,   1'b1, EV_ABSORB, 6'd0, 6'd0},  // tick after reset
        '{1'b0, K_BS,    1'b1, EV_ABSORB, 6'd0, 6'd0},  // backspace on empty line
        '{1'b0, K_CR,    1'b1, EV_SUBMIT, 6'd0, 6'd0},  // empty submit
        '{1'b0, K_PR_LO, 1'b1, EV_CHANGE, 6'd1, 6'd1},
        '{1'b0, K_PR_HI, 1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, 8'h41,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_ESC,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_LBRK,  1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_LEFT,  1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_ESC,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_SS3,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_HOME,  1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, 8'h00,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, 8'hFF,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_ESC,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_LBRK,  1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_THREE, 1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_TILDE, 1'b0, EV_ABSORB, 6'd0, 6'd0},  // delete at cursor
        '{1'b0, K_DEL,   1'b0, EV_ABSORB, 6'd0, 6'd0},  // no effect at column 0
        '{1'b0, K_ESC,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_SS3,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_END,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_ESC,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, 8'h78,   1'b0, EV_ABSORB, 6'd0, 6'd0},  // bare ESC cancels
        '{1'b0, 8'h42,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b0, K_LF,    1'b0, EV_ABSORB, 6'd0, 6'd0},  // submit one char
        '{1'b0, K_ESC,   1'b0, EV_ABSORB, 6'd0, 6'd0},
        '{1'b1, 8'h00,   1'b0, EV_ABSORB, 6'd0, 6'd0}   // tick after ESC cancels
    };

    int phase_limit [N_PHASES] = '{40, 3, 0, 63, 32};
    int phase_idle  [N_PHASES] = '{49, 0, 23, 49, 0};
    int phase_items [N_PHASES] = '{50, 34, 26, 36, 36};

    vt100_line_editor #(
        .LINE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_key_code   (i_key_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_event_res  (o_event_res),
        .o_char_out   (o_char_out),
        .o_char_valid (o_char_valid),
        .o_cursor_pos (o_cursor_pos),
        .o_line_length(o_line_length),
        .o_last       (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        if (mismatch_count < 60)
            $display("MISMATCH @%0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic add_result(input logic [1:0] ev, input logic [7:0] ch, input logic cv,
                              input logic last);
        t_line_result r;
        r = '{ev, ch, cv, ed_cursor[5:0], ed_length[5:0], last};
        pending_results.push_back(r);
    endtask

    task automatic clear_line();
        ed_cursor = 0;
        ed_length = 0;
        ed_phase  = PH_IDLE;
    endtask

    // Cursor keys after CSI or SS3
    function automatic logic [1:0] move_cursor(input logic [7:0] k);
        int old;
        old = ed_cursor;
        case (k)
            K_RIGHT: if (ed_cursor < ed_length) ed_cursor++;
            K_LEFT:  if (ed_cursor > 0) ed_cursor--;
            K_HOME:  ed_cursor = 0;
            K_END:   ed_cursor = ed_length;
            default: ;
        endcase
        return (ed_cursor != old) ? EV_CHANGE : EV_ABSORB;
    endfunction

    // Works out the results of one accepted item and updates the editor state
    task automatic predict_key(input logic f, input logic [7:0] k);
        logic [1:0] ev;
        int         lim;
        ev  = EV_ABSORB;
        lim = (ed_limit > DEPTH) ? DEPTH : ed_limit;
        if (f) begin
            if (ed_phase == PH_ESC) begin
                add_result(EV_CANCEL, 8'h00, 1'b0, 1'b1);
                clear_line();
            end else begin
                add_result(EV_ABSORB, 8'h00, 1'b0, 1'b1);
            end
            return;
        end
        case (ed_phase)
            PH_ESC: begin
                if (k == K_LBRK) begin
                    ed_phase = PH_CSI;
                end else if (k == K_SS3) begin
                    ed_phase = PH_SS3;
                end else begin
                    add_result(EV_CANCEL, 8'h00, 1'b0, 1'b1);
                    clear_line();
                    return;
                end
            end
            PH_CSI: begin
                if (k == K_THREE) begin
                    ed_phase = PH_CSI3;
                end else begin
                    ev = move_cursor(k);
                    ed_phase = PH_IDLE;
                end
            end
            PH_SS3: begin
                ev = move_cursor(k);
                ed_phase = PH_IDLE;
            end
            PH_CSI3: begin
                if (k == K_TILDE && ed_cursor < ed_length) begin
                    for (int i = ed_cursor; i + 1 < ed_length; i++)
                        ed_line[i] = ed_line[i + 1];
                    ed_length--;
                    ev = EV_CHANGE;
                end
                ed_phase = PH_IDLE;
            end
            default: begin
                ed_phase = PH_IDLE;
                if (k == K_CR || k == K_LF) begin
                    // submit: one result per char, or one empty result
                    if (ed_length == 0) begin
                        add_result(EV_SUBMIT, 8'h00, 1'b0, 1'b1);
                    end else begin
                        for (int i = 0; i < ed_length; i++)
                            add_result(EV_SUBMIT, ed_line[i], 1'b1, i == ed_length - 1);
                    end
                    clear_line();
                    return;
                end
                if (k == K_ESC) begin
                    ed_phase = PH_ESC;
                end else if (k == K_BS || k == K_DEL) begin
                    if (ed_cursor > 0) begin
                        for (int i = ed_cursor - 1; i + 1 < ed_length; i++)
                            ed_line[i] = ed_line[i + 1];
                        ed_length--;
                        ed_cursor--;
                        ev = EV_CHANGE;
                    end
                end else if (k >= K_PR_LO && k <= K_PR_HI) begin
                    if (ed_length < lim) begin
                        for (int i = ed_length; i > ed_cursor; i--)
                            ed_line[i] = ed_line[i - 1];
                        ed_line[ed_cursor] = k;
                        ed_length++;
                        ed_cursor++;
                        ev = EV_CHANGE;
                    end
                end
            end
        endcase
        add_result(ev, 8'h00, 1'b0, 1'b1);
    endtask

    // Drive one item, with an optional random gap in front of it
    task automatic send_key(input logic f, input logic [7:0] k, input int idle_pct);
        int gap;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_func     <= f;
        i_key_code <= k;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_key(f, k);
    endtask

    function automatic logic [7:0] pick_cursor_key();
        case ($urandom_range(3, 0))
            0:       return K_RIGHT;
            1:       return K_LEFT;
            2:       return K_HOME;
            default: return K_END;
        endcase
    endfunction

    // One editing action; returns the number of items it took
    task automatic random_action(input int idle_pct, output int n);
        int         pick;
        logic [7:0] k;
        pick = $urandom_range(99, 0);
        n = 1;
        if (pick < 45) begin
            send_key(1'b0, 8'($urandom_range(K_PR_HI, K_PR_LO)), idle_pct);
        end else if (pick < 55) begin
            send_key(1'b0, $urandom_range(1, 0) ? K_BS : K_DEL, idle_pct);
        end else if (pick < 60) begin
            send_key(1'b0, K_ESC, idle_pct);
            send_key(1'b0, K_LBRK, idle_pct);
            send_key(1'b0, K_THREE, idle_pct);
            send_key(1'b0, K_TILDE, idle_pct);
            n = 4;
        end else if (pick < 72) begin
            send_key(1'b0, K_ESC, idle_pct);
            send_key(1'b0, $urandom_range(1, 0) ? K_LBRK : K_SS3, idle_pct);
            send_key(1'b0, pick_cursor_key(), idle_pct);
            n = 3;
        end else if (pick < 75) begin
            send_key(1'b0, $urandom_range(1, 0) ? K_CR : K_LF, idle_pct);
        end else if (pick < 78) begin
            // bare ESC: any other byte, or a tick
            send_key(1'b0, K_ESC, idle_pct);
            if ($urandom_range(1, 0)) begin
                do k = 8'($urandom_range(255, 0)); while (k == K_LBRK || k == K_SS3);
                send_key(1'b0, k, idle_pct);
            end else begin
                send_key(1'b1, 8'($urandom_range(255, 0)), idle_pct);
            end
            n = 2;
        end else if (pick < 85) begin
            // broken or unknown sequences
            send_key(1'b0, K_ESC, idle_pct);
            case ($urandom_range(2, 0))
                0: begin
                    send_key(1'b0, K_LBRK, idle_pct);
                    n = 3;
                end
                1: begin
                    send_key(1'b0, K_SS3, idle_pct);
                    n = 3;
                end
                default: begin
                    send_key(1'b0, K_LBRK, idle_pct);
                    send_key(1'b0, K_THREE, idle_pct);
                    n = 4;
                end
            endcase
            send_key(1'b0, 8'($urandom_range(255, 0)), idle_pct);
        end else if (pick < 93) begin
            send_key(1'b1, 8'($urandom_range(255, 0)), idle_pct);
        end else begin
            send_key(1'b0, 8'($urandom_range(255, 0)), idle_pct);
        end
    endtask

    // Waits for all results, then writes the line limit
    task automatic set_line_limit(input logic [5:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ed_limit = value;
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_line_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result ev=%0d ch=%h cur=%0d len=%0d",
                                        o_event_res, o_char_out, o_cursor_pos,
                                        o_line_length));
            end else begin
                want = pending_results.pop_front();
                if (o_event_res !== want.ev)
                    flag_mismatch($sformatf("event %0d, want %0d", o_event_res, want.ev));
                if (o_char_out !== want.ch)
                    flag_mismatch($sformatf("char %h, want %h", o_char_out, want.ch));
                if (o_char_valid !== want.cv)
                    flag_mismatch($sformatf("char_valid %b, want %b", o_char_valid, want.cv));
                if (o_cursor_pos !== want.cur)
                    flag_mismatch($sformatf("cursor %0d, want %0d", o_cursor_pos, want.cur));
                if (o_line_length !== want.len)
                    flag_mismatch($sformatf("length %0d, want %0d", o_line_length, want.len));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("last %b, want %b", o_last, want.last));
            end
        end
    end

    initial begin : stimulus
        int sent;
        int n;
        ed_cursor = 0;
        ed_length = 0;
        ed_phase  = PH_IDLE;
        ed_limit  = LIMIT_RESET;
        for (int i = 0; i < DEPTH; i++) ed_line[i] = 8'h00;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, back to back
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_key(directed_rows[r].func, directed_rows[r].key, 0);
            if (directed_rows[r].typed)
                pending_results[pending_results.size() - 1] =
                    '{directed_rows[r].ev, 8'h00, 1'b0, directed_rows[r].cur,
                      directed_rows[r].len, 1'b1};
        end

        // Random editing, one line limit per phase; the line carries over
        for (int p = 0; p < N_PHASES; p++) begin
            set_line_limit(6'(phase_limit[p]));
            sent = 0;
            while (sent < phase_items[p]) begin
                random_action(phase_idle[p], n);
                sent += n;
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
